// File: hw/rtl/tlba_pkg.sv
// Shared constants, codes and types of the two-level bitmap index allocator.
// Used by tlba_ctrl, tlba_datapath and two_level_bitmap_index_allocator_core.
package tlba_pkg;

  localparam int WORD_BITS  = 64;
  localparam int LEAF_WORDS = 64;
  localparam int TOTAL      = WORD_BITS * LEAF_WORDS;

  localparam int IDX_W  = 12;
  localparam int CNT_W  = 13;
  localparam int BIT_W  = $clog2(WORD_BITS);
  localparam int WORD_W = (LEAF_WORDS > 1) ? $clog2(LEAF_WORDS) : 1;
  localparam int WSEL_W = $clog2(LEAF_WORDS + 1);
  localparam int POS_W  = 7;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_ALLOC = 2'd2;

  typedef struct packed {
    logic accept;
    logic commit;
  } tlba_cmd_t;

  // lowest clear bit below limit, or limit when none
  function automatic logic [POS_W-1:0] lowest_clear(input logic [63:0] w, input int limit);
    logic [POS_W-1:0] pos;
    pos = POS_W'(limit);
    for (int i = 63; i >= 0; i--) begin
      if (i < limit && !w[i]) begin
        pos = POS_W'(i);
      end
    end
    return pos;
  endfunction

endpackage

// File: hw/rtl/tlba_ctrl.sv
// Controller of the allocator: accept / execute sequencing and result valid.
// Depends on tlba_pkg for the command struct.
module tlba_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output tlba_pkg::tlba_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r;
  logic   out_valid_r;

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign cmd.accept = in_valid && (state_r == S_IDLE);
  assign cmd.commit = (state_r == S_EXEC) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (cmd.accept) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (cmd.commit) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// File: hw/rtl/tlba_datapath.sv
// Datapath of the allocator: summary word, leaf word memory, free count, result register.
// Depends on tlba_pkg; driven by tlba_ctrl through tlba_cmd_t.
module tlba_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  tlba_pkg::tlba_cmd_t            cmd,
  input  logic [1:0]                     in_opcode,
  input  logic [tlba_pkg::IDX_W-1:0]     in_index,
  output logic [tlba_pkg::IDX_W-1:0]     out_granted_index,
  output logic [1:0]                     out_status,
  output logic [tlba_pkg::CNT_W-1:0]     out_remaining_count
);

  localparam int WB  = tlba_pkg::WORD_BITS;
  localparam int LW  = tlba_pkg::LEAF_WORDS;
  localparam int IW  = tlba_pkg::IDX_W;
  localparam int CW  = tlba_pkg::CNT_W;
  localparam int BW  = tlba_pkg::BIT_W;
  localparam int AW  = tlba_pkg::WORD_W;
  localparam int SW  = tlba_pkg::WSEL_W;
  localparam int PW  = tlba_pkg::POS_W;

  logic [WB-1:0] leaf_mem [LW];
  logic [WB-1:0] rd_data_r;
  logic          rd_valid_r;

  logic [LW-1:0] summary_r, summary_nxt;
  logic [LW-1:0] valid_r, valid_nxt;
  logic [CW-1:0] count_r, count_nxt;

  logic [1:0]    op_r;
  logic [SW-1:0] w_r;
  logic [BW-1:0] b_r;
  logic          bad_r;

  logic [IW-1:0] out_granted_r, granted_nxt;
  logic [1:0]    out_status_r, status_nxt;
  logic [CW-1:0] out_count_r;

  // accept side
  logic [PW-1:0] sum_pos;
  logic [IW-1:0] idx_div, idx_mod;
  logic [SW-1:0] word_sel;
  logic [AW-1:0] rd_addr;
  logic          range_bad;

  always_comb begin
    sum_pos   = tlba_pkg::lowest_clear(64'(summary_r), LW);
    idx_div   = in_index / IW'(WB);
    idx_mod   = in_index % IW'(WB);
    range_bad = (CW'(in_index) >= CW'(tlba_pkg::TOTAL));
    word_sel  = (in_opcode == tlba_pkg::OP_ALLOC) ? sum_pos[SW-1:0] : idx_div[SW-1:0];
    rd_addr   = word_sel[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r       <= in_opcode;
      w_r        <= word_sel;
      b_r        <= idx_mod[BW-1:0];
      bad_r      <= (in_opcode == tlba_pkg::OP_ALLOC) ? (sum_pos >= PW'(LW)) : range_bad;
      rd_data_r  <= leaf_mem[rd_addr];
      rd_valid_r <= valid_r[rd_addr];
    end
  end

  // execute side
  logic [WB-1:0] word, bit_mask, wr_data;
  logic [PW-1:0] leaf_pos;
  logic [BW-1:0] bit_sel;
  logic [AW-1:0] word_addr;
  logic          wr_en;

  always_comb begin
    word        = rd_valid_r ? rd_data_r : '0;
    leaf_pos    = tlba_pkg::lowest_clear(64'(word), WB);
    bit_sel     = (op_r == tlba_pkg::OP_ALLOC) ? leaf_pos[BW-1:0] : b_r;
    bit_mask    = {{(WB-1){1'b0}}, 1'b1} << bit_sel;
    word_addr   = w_r[AW-1:0];
    wr_en       = 1'b0;
    wr_data     = word;
    summary_nxt = summary_r;
    valid_nxt   = valid_r;
    count_nxt   = count_r;
    granted_nxt = '0;
    status_nxt  = tlba_pkg::ST_OK;
    unique case (op_r)
      tlba_pkg::OP_ALLOC: begin
        if (bad_r || leaf_pos >= PW'(WB)) begin
          status_nxt = tlba_pkg::ST_FULL;
        end else begin
          wr_en                = 1'b1;
          wr_data              = word | bit_mask;
          valid_nxt[word_addr] = 1'b1;
          if (&(word | bit_mask)) begin
            summary_nxt[word_addr] = 1'b1;
          end
          if (count_r != '0) begin
            count_nxt = count_r - CW'(1);
          end
          granted_nxt = IW'(IW'(w_r) * IW'(WB) + IW'(bit_sel));
        end
      end
      tlba_pkg::OP_FREE: begin
        if (bad_r || !word[b_r]) begin
          status_nxt = tlba_pkg::ST_NOT_ALLOC;
        end else begin
          wr_en                  = 1'b1;
          wr_data                = word & ~bit_mask;
          valid_nxt[word_addr]   = 1'b1;
          summary_nxt[word_addr] = 1'b0;
          if (count_r < CW'(tlba_pkg::TOTAL)) begin
            count_nxt = count_r + CW'(1);
          end
        end
      end
      tlba_pkg::OP_CLEAR: begin
        valid_nxt   = '0;
        summary_nxt = '0;
        count_nxt   = CW'(tlba_pkg::TOTAL);
      end
      tlba_pkg::OP_NOP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && wr_en) begin
      leaf_mem[word_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      summary_r <= '0;
      valid_r   <= '0;
      count_r   <= CW'(tlba_pkg::TOTAL);
    end else if (cmd.commit) begin
      summary_r <= summary_nxt;
      valid_r   <= valid_nxt;
      count_r   <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_granted_r <= granted_nxt;
      out_status_r  <= status_nxt;
      out_count_r   <= count_nxt;
    end
  end

  assign out_granted_index   = out_granted_r;
  assign out_status          = out_status_r;
  assign out_remaining_count = out_count_r;

endmodule

// File: hw/rtl/two_level_bitmap_index_allocator_core.sv
// Top level of the two-level bitmap index allocator.
// Depends on tlba_pkg, tlba_ctrl and tlba_datapath.
//
// Usage:
//   Input channel (in_valid/in_ready): one item per operation, in_opcode
//   selects allocate, free, clear or no operation; in_index is the index to free.
//   Result channel (out_valid/out_ready): exactly one item per input item,
//   with the granted index, a status code and the free count afterwards.
//   Sequencing: an accepted item moves to the execute state, which commits
//   its result to the output register; a new item is taken only in idle.
//   The accept step reads the leaf word from the leaf memory, the execute
//   step modifies and writes it back, which the next item may need.
//   Stall: a finished result waits in the output register; a new item is
//   accepted meanwhile, and its execute cycle holds until the slot frees.
//   Reset: synchronous, active low; all indices free (count 4096), summary
//   cleared and every leaf word marked unwritten, so no clearing pass is run.
//   A clear item has the same effect within its execute cycle.
module two_level_bitmap_index_allocator_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_opcode,
  input  logic [tlba_pkg::IDX_W-1:0] in_index,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [tlba_pkg::IDX_W-1:0] out_granted_index,
  output logic [1:0]                 out_status,
  output logic [tlba_pkg::CNT_W-1:0] out_remaining_count
);

  tlba_pkg::tlba_cmd_t cmd;

  tlba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  tlba_datapath u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .in_opcode           (in_opcode),
    .in_index            (in_index),
    .out_granted_index   (out_granted_index),
    .out_status          (out_status),
    .out_remaining_count (out_remaining_count)
  );

endmodule
